// File: hdl/tcci_pkg.sv
// ----------------------------------------------------------------------------
// tcci_pkg
// Shared types and constants of the terminal control code interpreter.
// ----------------------------------------------------------------------------
package tcci_pkg;

	// Screen geometry limits and tab spacing
	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;
	localparam int TAB_WIDTH   = 8;

	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int TAB_W  = COL_W + 2;
	localparam int CMP_W  = 9;

	// Configuration register widths and indexes
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int COLS_CFG_W  = 8;
	localparam int ROWS_CFG_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OVERWRITE_MODE = 2'd2;

	// Frame-buffer operation codes
	localparam logic [2:0] OP_WRITE_CHAR   = 3'd0;
	localparam logic [2:0] OP_CLEAR_LINE   = 3'd1;
	localparam logic [2:0] OP_INSERT_LINE  = 3'd2;
	localparam logic [2:0] OP_DELETE_LINE  = 3'd3;
	localparam logic [2:0] OP_CLEAR_SCREEN = 3'd4;
	localparam logic [2:0] OP_CLEAR_EOL    = 3'd5;
	localparam logic [2:0] OP_BELL         = 3'd6;

	// Control characters (seven-bit)
	localparam logic [6:0] CH_NUL      = 7'h00;
	localparam logic [6:0] CH_INS_LINE = 7'h01;
	localparam logic [6:0] CH_DEL_LINE = 7'h02;
	localparam logic [6:0] CH_SO_ON    = 7'h05;
	localparam logic [6:0] CH_SO_OFF   = 7'h06;
	localparam logic [6:0] CH_BELL     = 7'h07;
	localparam logic [6:0] CH_BS       = 7'h08;
	localparam logic [6:0] CH_TAB      = 7'h09;
	localparam logic [6:0] CH_LF       = 7'h0A;
	localparam logic [6:0] CH_UP       = 7'h0B;
	localparam logic [6:0] CH_CLEAR    = 7'h0C;
	localparam logic [6:0] CH_CR       = 7'h0D;
	localparam logic [6:0] CH_FWD      = 7'h18;
	localparam logic [6:0] CH_EOL      = 7'h19;
	localparam logic [6:0] CH_ESC      = 7'h1B;
	localparam logic [6:0] CH_EQUALS   = 7'h3D;
	localparam logic [6:0] ADDR_BIAS   = 7'd32;

	// Effective screen limits handed to the front end
	typedef struct packed {
		logic [COL_W-1:0] last_col;
		logic [ROW_W-1:0] last_row;
		logic             overwrite;
	} limits_t;

	// One frame-buffer operation
	typedef struct packed {
		logic [2:0]       operation;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic [6:0]       glyph;
		logic             highlight;
	} fb_op_t;

	// Everything one input word produces
	typedef struct packed {
		fb_op_t first;
		fb_op_t second;
		logic   two;
	} run_t;

endpackage

// File: hdl/tcci_front.sv
// ----------------------------------------------------------------------------
// tcci_front
// Decodes input words, tracks cursor and escape state, builds operation runs.
// ----------------------------------------------------------------------------
module tcci_front
	import tcci_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  limits_t    limits,
	input  logic [7:0] data_byte,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic       queue_full,
	output logic       push,
	output run_t       push_run
);

	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_SEEN = 2'd1;
	localparam logic [1:0] ESC_ROW  = 2'd2;
	localparam logic [1:0] ESC_COL  = 2'd3;
	localparam int NUM_STOPS = MAX_COLUMNS / TAB_WIDTH + 1;

	logic [ROW_W-1:0] cursor_row_q, pending_row_q;
	logic [COL_W-1:0] cursor_col_q;
	logic             standout_q;
	logic [1:0]       phase_q;

	logic [6:0]       b;
	logic [ROW_W-1:0] r0, p0, lf_row, nxt_row, nxt_pend;
	logic [COL_W-1:0] c0, c1, c2, nxt_col, tab_col;
	logic             nxt_so, lf_emit;
	logic [1:0]       nxt_phase;
	logic [1:0]       cnt;
	fb_op_t           op_a, op_b, lf_op;
	logic [TAB_W-1:0] tab_stop;
	logic [CMP_W-1:0] addr, row_addr_c, col_addr_c;
	logic             accept;

	assign b          = data_byte[6:0];
	assign byte_ready = !queue_full;
	assign accept     = byte_valid && byte_ready;

	// Pull a cursor left outside a shrunk screen back onto it
	assign r0 = (cursor_row_q > limits.last_row) ? limits.last_row : cursor_row_q;
	assign p0 = (pending_row_q > limits.last_row) ? limits.last_row : pending_row_q;
	assign c0 = (cursor_col_q > limits.last_col) ? limits.last_col : cursor_col_q;

	assign c1 = (c0 < limits.last_col) ? c0 + 1'b1 : c0;
	assign c2 = (c1 < limits.last_col) ? c1 + 1'b1 : c1;

	// Address byte less the bias, clamped against each limit
	assign addr       = (b < ADDR_BIAS) ? '0 : CMP_W'(b - ADDR_BIAS);
	assign row_addr_c = (addr > CMP_W'(limits.last_row)) ? CMP_W'(limits.last_row) : addr;
	assign col_addr_c = (addr > CMP_W'(limits.last_col)) ? CMP_W'(limits.last_col) : addr;

	// Next tab stop: smallest multiple of the tab width above the column
	always_comb begin
		tab_stop = '0;
		for (int k = NUM_STOPS; k >= 1; k--) begin
			if (TAB_W'(c0) < TAB_W'(k * TAB_WIDTH)) begin
				tab_stop = TAB_W'(k * TAB_WIDTH);
			end
		end
	end
	assign tab_col = (tab_stop > TAB_W'(limits.last_col)) ? limits.last_col
		: tab_stop[COL_W-1:0];

	// Line feed from the current row
	always_comb begin
		lf_op = '0;
		if (r0 >= limits.last_row) begin
			lf_emit      = 1'b1;
			lf_row       = limits.overwrite ? '0 : limits.last_row;
			lf_op.operation = limits.overwrite ? OP_CLEAR_LINE : OP_DELETE_LINE;
		end else begin
			lf_emit      = limits.overwrite;
			lf_row       = r0 + 1'b1;
			lf_op.operation = OP_CLEAR_LINE;
			lf_op.row    = r0 + 1'b1;
		end
	end

	always_comb begin
		nxt_row   = r0;
		nxt_col   = c0;
		nxt_pend  = p0;
		nxt_so    = standout_q;
		nxt_phase = phase_q;
		cnt       = 2'd0;
		op_a      = '0;
		op_b      = '0;
		case (phase_q)
			ESC_SEEN: begin
				if (b != CH_EQUALS) begin
					nxt_phase = ESC_IDLE;
					op_a = '{OP_WRITE_CHAR, r0, c0, CH_ESC, standout_q};
					op_b = '{OP_WRITE_CHAR, r0, c1, b, standout_q};
					nxt_col = c2;
					cnt = 2'd2;
				end else begin
					nxt_phase = ESC_ROW;
				end
			end
			ESC_ROW: begin
				nxt_pend  = row_addr_c[ROW_W-1:0];
				nxt_phase = ESC_COL;
			end
			ESC_COL: begin
				nxt_row   = p0;
				nxt_col   = col_addr_c[COL_W-1:0];
				nxt_phase = ESC_IDLE;
			end
			default: begin
				case (b)
					CH_CR: nxt_col = '0;
					CH_LF: begin
						nxt_row = lf_row;
						op_a    = lf_op;
						cnt     = {1'b0, lf_emit};
					end
					CH_UP: if (r0 != '0) nxt_row = r0 - 1'b1;
					CH_CLEAR: begin
						op_a.operation = OP_CLEAR_SCREEN;
						cnt     = 2'd1;
						nxt_row = '0;
						nxt_col = '0;
					end
					CH_ESC: nxt_phase = ESC_SEEN;
					CH_TAB: nxt_col = tab_col;
					CH_BS: if (c0 != '0) nxt_col = c0 - 1'b1;
					CH_SO_ON: nxt_so = 1'b1;
					CH_SO_OFF: nxt_so = 1'b0;
					CH_BELL: begin
						op_a.operation = OP_BELL;
						cnt = 2'd1;
					end
					CH_FWD: begin
						if (c0 < limits.last_col) begin
							nxt_col = c0 + 1'b1;
						end else begin
							nxt_col = '0;
							if (r0 < limits.last_row) nxt_row = r0 + 1'b1;
						end
					end
					CH_INS_LINE: begin
						op_a = '{OP_INSERT_LINE, r0, '0, '0, 1'b0};
						cnt  = 2'd1;
					end
					CH_DEL_LINE: begin
						op_a = '{OP_DELETE_LINE, r0, '0, '0, 1'b0};
						cnt  = 2'd1;
					end
					CH_EOL: begin
						op_a = '{OP_CLEAR_EOL, r0, c0, '0, 1'b0};
						cnt  = 2'd1;
					end
					CH_NUL: ;
					default: begin
						op_a = '{OP_WRITE_CHAR, r0, c0, b, standout_q};
						if (c0 >= limits.last_col) begin
							nxt_col = '0;
							nxt_row = lf_row;
							op_b    = lf_op;
							cnt     = lf_emit ? 2'd2 : 2'd1;
						end else begin
							nxt_col = c0 + 1'b1;
							cnt     = 2'd1;
						end
					end
				endcase
			end
		endcase
	end

	assign push            = accept && (cnt != 2'd0);
	assign push_run.first  = op_a;
	assign push_run.second = op_b;
	assign push_run.two    = cnt[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q  <= '0;
			cursor_col_q  <= '0;
			pending_row_q <= '0;
			standout_q    <= 1'b0;
			phase_q       <= ESC_IDLE;
		end else if (accept) begin
			cursor_row_q  <= nxt_row;
			cursor_col_q  <= nxt_col;
			pending_row_q <= nxt_pend;
			standout_q    <= nxt_so;
			phase_q       <= nxt_phase;
		end
	end

endmodule

// File: hdl/tcci_queue.sv
// ----------------------------------------------------------------------------
// tcci_queue
// Two-entry queue of operation runs between front and back end.
// ----------------------------------------------------------------------------
module tcci_queue
	import tcci_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_run,
	input  logic pop,
	output run_t head,
	output logic empty,
	output logic full
);

	run_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/tcci_back.sv
// ----------------------------------------------------------------------------
// tcci_back
// Issues queued runs one operation per word on the output channel.
// ----------------------------------------------------------------------------
module tcci_back
	import tcci_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  run_t             head,
	input  logic             empty,
	output logic             pop,
	output logic             op_valid,
	input  logic             op_ready,
	output logic [2:0]       operation,
	output logic [ROW_W-1:0] target_row,
	output logic [COL_W-1:0] target_column,
	output logic [6:0]       glyph,
	output logic             highlight,
	output logic             last_of_run
);

	fb_op_t out_op_q, second_q;
	logic   out_valid_q, out_last_q, second_valid_q;
	logic   load;

	// Output register free: either empty or its word leaves this cycle
	assign load = !out_valid_q || op_ready;
	assign pop  = load && !second_valid_q && !empty;

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_valid_q) begin
				out_op_q   <= second_q;
				out_last_q <= 1'b1;
			end else begin
				out_op_q   <= head.first;
				out_last_q <= !head.two;
			end
		end
		if (pop) second_q <= head.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			second_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q    <= second_valid_q || !empty;
			second_valid_q <= pop && head.two;
		end
	end

	assign op_valid      = out_valid_q;
	assign operation     = out_op_q.operation;
	assign target_row    = out_op_q.row;
	assign target_column = out_op_q.column;
	assign glyph         = out_op_q.glyph;
	assign highlight     = out_op_q.highlight;
	assign last_of_run   = out_last_q;

endmodule

// File: hdl/terminal_control_code_interpreter.sv
// ----------------------------------------------------------------------------
// terminal_control_code_interpreter
// Dumb-terminal byte stream in, frame-buffer operations out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel byte_valid/byte_ready carries one host output word per
//   handshake; bit 7 of data_byte is ignored. Output channel op_valid/op_ready
//   carries one frame-buffer operation per word; last_of_run marks the final
//   operation caused by an input word. Words that only move the cursor, set
//   standout or step the cursor-address escape produce nothing.
//   After its input word is taken, an operation passes through the queue
//   slot, written by the front end as it decodes the word, and then the
//   back-end output register before it appears on the output. The block
//   takes one input word per cycle while the queue has space; a word that
//   causes two operations (escape without '=', write with line feed in
//   overwrite or scroll) issues them one after the other from the back end.
//   When the receiver stalls, the two-entry queue fills and byte_ready drops;
//   the front end holds its state until space returns.
//   Reset clears cursor, standout, escape state and queue, and loads the
//   screen registers with 80 columns, 24 rows and scroll mode.
//   Write screen registers through cfg_write_enable/cfg_index/cfg_data only
//   while the block is idle.
// ----------------------------------------------------------------------------
module terminal_control_code_interpreter
	import tcci_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_enable,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  logic [7:0]             data_byte,
	output logic                   op_valid,
	input  logic                   op_ready,
	output logic [2:0]             operation,
	output logic [ROW_W-1:0]       target_row,
	output logic [COL_W-1:0]       target_column,
	output logic [6:0]             glyph,
	output logic                   highlight,
	output logic                   last_of_run
);

	logic [COLS_CFG_W-1:0] screen_columns_q;
	logic [ROWS_CFG_W-1:0] screen_rows_q;
	logic                  overwrite_q;
	limits_t               limits;

	logic push, pop, q_empty, q_full;
	run_t push_run, head;

	// Screen registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_columns_q <= COLS_CFG_W'(80);
			screen_rows_q    <= ROWS_CFG_W'(24);
			overwrite_q      <= 1'b0;
		end else if (cfg_write_enable) begin
			case (cfg_index)
				REG_SCREEN_COLUMNS: screen_columns_q <= cfg_data[COLS_CFG_W-1:0];
				REG_SCREEN_ROWS:    screen_rows_q    <= cfg_data[ROWS_CFG_W-1:0];
				REG_OVERWRITE_MODE: overwrite_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Effective last column and row: zero acts as one, oversize as the maximum
	always_comb begin
		if (screen_columns_q == '0) begin
			limits.last_col = '0;
		end else if (CMP_W'(screen_columns_q) > CMP_W'(MAX_COLUMNS)) begin
			limits.last_col = COL_W'(MAX_COLUMNS - 1);
		end else begin
			limits.last_col = COL_W'(CMP_W'(screen_columns_q) - CMP_W'(1));
		end
		if (screen_rows_q == '0) begin
			limits.last_row = '0;
		end else if (CMP_W'(screen_rows_q) > CMP_W'(MAX_ROWS)) begin
			limits.last_row = ROW_W'(MAX_ROWS - 1);
		end else begin
			limits.last_row = ROW_W'(CMP_W'(screen_rows_q) - CMP_W'(1));
		end
		limits.overwrite = overwrite_q;
	end

	tcci_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.limits     (limits),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.queue_full (q_full),
		.push       (push),
		.push_run   (push_run)
	);

	tcci_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	tcci_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.op_valid      (op_valid),
		.op_ready      (op_ready),
		.operation     (operation),
		.target_row    (target_row),
		.target_column (target_column),
		.glyph         (glyph),
		.highlight     (highlight),
		.last_of_run   (last_of_run)
	);

endmodule

// File: tb/terminal_control_code_interpreter_checker.sv
// ----------------------------------------------------------------------------
// terminal_control_code_interpreter_checker
// Watches the byte and operation channels and the register port, keeps its
// own copy of the cursor, attribute and escape state, and compares every
// frame-buffer operation with the next one it worked out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module terminal_control_code_interpreter_checker
	import tcci_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_enable,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   byte_valid,
	input  logic                   byte_ready,
	input  logic [7:0]             data_byte,
	input  logic                   op_valid,
	input  logic                   op_ready,
	input  logic [2:0]             operation,
	input  logic [ROW_W-1:0]       target_row,
	input  logic [COL_W-1:0]       target_column,
	input  logic [6:0]             glyph,
	input  logic                   highlight,
	input  logic                   last_of_run,
	output int                     fail_count,
	output int                     outstanding
);

	typedef struct packed {
		logic [2:0]       operation;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic [6:0]       glyph;
		logic             highlight;
		logic             last;
	} fb_word_t;

	typedef enum logic [1:0] {ESC_IDLE, ESC_AFTER, ESC_ROW, ESC_COL} esc_state_t;

	logic [7:0] cfg_columns;
	logic [6:0] cfg_rows;
	logic       cfg_overwrite;

	int         cur_row;
	int         cur_col;
	int         held_row;
	logic       standout;
	esc_state_t esc_state;

	fb_word_t   run_ops[$];
	fb_word_t   fb_ops_due[$];
	fb_word_t   head;

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	function automatic int clamp_address(input int code, input int limit);
		if (code < ADDR_BIAS)
			return 0;
		code = code - ADDR_BIAS;
		return (code > limit - 1) ? limit - 1 : code;
	endfunction

	task automatic add_op(input logic [2:0] op, input int row, input int col,
			input logic [6:0] g, input logic hl);
		fb_word_t w;
		w.operation = op;
		w.row       = row[ROW_W-1:0];
		w.column    = col[COL_W-1:0];
		w.glyph     = g;
		w.highlight = hl;
		w.last      = 1'b0;
		run_ops.push_back(w);
	endtask

	// Line feed: scroll or wrap-and-clear at the bottom row, else step down and clear the new line in overwrite mode
	task automatic advance_line(input int rows);
		if (cur_row >= rows - 1) begin
			if (cfg_overwrite) begin
				cur_row = 0;
				add_op(OP_CLEAR_LINE, 0, 0, 7'd0, 1'b0);
			end else begin
				cur_row = rows - 1;
				add_op(OP_DELETE_LINE, 0, 0, 7'd0, 1'b0);
			end
		end else begin
			cur_row++;
			if (cfg_overwrite)
				add_op(OP_CLEAR_LINE, cur_row, 0, 7'd0, 1'b0);
		end
	endtask

	task automatic interpret_word(input logic [7:0] word);
		logic [6:0] c;
		int         cols;
		int         rows;
		int         x;
		fb_word_t   w;
		c    = word[6:0];
		cols = int'(cfg_columns);
		rows = int'(cfg_rows);
		if (cols < 1)
			cols = 1;
		if (cols > MAX_COLUMNS)
			cols = MAX_COLUMNS;
		if (rows < 1)
			rows = 1;
		if (rows > MAX_ROWS)
			rows = MAX_ROWS;
		run_ops.delete();

		// Pull the cursor back inside a screen that has shrunk
		if (cur_row > rows - 1)
			cur_row = rows - 1;
		if (cur_col > cols - 1)
			cur_col = cols - 1;
		if (held_row > rows - 1)
			held_row = rows - 1;

		case (esc_state)
			ESC_AFTER: begin
				if (c != CH_EQUALS) begin
					esc_state = ESC_IDLE;
					add_op(OP_WRITE_CHAR, cur_row, cur_col, CH_ESC, standout);
					if (cur_col < cols - 1)
						cur_col++;
					add_op(OP_WRITE_CHAR, cur_row, cur_col, c, standout);
					if (cur_col < cols - 1)
						cur_col++;
				end else begin
					esc_state = ESC_ROW;
				end
			end
			ESC_ROW: begin
				held_row  = clamp_address(c, rows);
				esc_state = ESC_COL;
			end
			ESC_COL: begin
				cur_row   = held_row;
				cur_col   = clamp_address(c, cols);
				esc_state = ESC_IDLE;
			end
			default: begin
				x = cur_col;
				case (c)
					CH_CR:       cur_col = 0;
					CH_LF:       advance_line(rows);
					CH_UP:       if (cur_row > 0) cur_row--;
					CH_CLEAR: begin
						add_op(OP_CLEAR_SCREEN, 0, 0, 7'd0, 1'b0);
						cur_row = 0;
						cur_col = 0;
					end
					CH_ESC:      esc_state = ESC_AFTER;
					CH_TAB: begin
						x       = x + TAB_WIDTH - (x % TAB_WIDTH);
						cur_col = (x > cols - 1) ? cols - 1 : x;
					end
					CH_BS:       if (x > 0) cur_col--;
					CH_SO_ON:    standout = 1'b1;
					CH_SO_OFF:   standout = 1'b0;
					CH_BELL:     add_op(OP_BELL, 0, 0, 7'd0, 1'b0);
					CH_FWD: begin
						if (x < cols - 1) begin
							cur_col = x + 1;
						end else begin
							cur_col = 0;
							if (cur_row < rows - 1)
								cur_row++;
						end
					end
					CH_INS_LINE: add_op(OP_INSERT_LINE, cur_row, 0, 7'd0, 1'b0);
					CH_DEL_LINE: add_op(OP_DELETE_LINE, cur_row, 0, 7'd0, 1'b0);
					CH_EOL:      add_op(OP_CLEAR_EOL, cur_row, x, 7'd0, 1'b0);
					CH_NUL: ;
					default: begin
						add_op(OP_WRITE_CHAR, cur_row, x, c, standout);
						if (x >= cols - 1) begin
							cur_col = 0;
							advance_line(rows);
						end else begin
							cur_col = x + 1;
						end
					end
				endcase
			end
		endcase

		// Mark the final operation of the run, then queue the lot
		if (run_ops.size() > 0) begin
			w      = run_ops.pop_back();
			w.last = 1'b1;
			run_ops.push_back(w);
		end
		foreach (run_ops[i])
			fb_ops_due.push_back(run_ops[i]);
	endtask

	task automatic compare_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_columns   = 8'd80;
			cfg_rows      = 7'd24;
			cfg_overwrite = 1'b0;
			cur_row       = 0;
			cur_col       = 0;
			held_row      = 0;
			standout      = 1'b0;
			esc_state     = ESC_IDLE;
			fb_ops_due.delete();
			outstanding   = 0;
		end else begin
			if (cfg_write_enable) begin
				case (cfg_index)
					REG_SCREEN_COLUMNS: cfg_columns   = cfg_data;
					REG_SCREEN_ROWS:    cfg_rows      = cfg_data[6:0];
					REG_OVERWRITE_MODE: cfg_overwrite = cfg_data[0];
					default: ;
				endcase
			end
			if (byte_valid && byte_ready)
				interpret_word(data_byte);
			if (op_valid && op_ready) begin
				if (fb_ops_due.size() == 0) begin
					$error("operation word with nothing due: op %0d row %0d col %0d glyph %0d",
						operation, target_row, target_column, glyph);
					fail_count++;
				end else begin
					head = fb_ops_due.pop_front();
					compare_field("operation", head.operation, operation);
					compare_field("target_row", head.row, target_row);
					compare_field("target_column", head.column, target_column);
					compare_field("glyph", head.glyph, glyph);
					compare_field("highlight", head.highlight, highlight);
					compare_field("last_of_run", head.last, last_of_run);
				end
			end
			outstanding = fb_ops_due.size();
		end
	end

endmodule

// File: tb/terminal_control_code_interpreter_test.sv
// ----------------------------------------------------------------------------
// terminal_control_code_interpreter_test
// Drives host output words into the interpreter under several screen
// settings, with random idling on both channels, and leaves the checking of
// every frame-buffer operation to the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module terminal_control_code_interpreter_test
	import tcci_pkg::*;
();

	// Generous ceiling for a correct run
	localparam int CYCLE_LIMIT = 200000;
	// Index with no register behind it
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk;
	logic                   arst_n           = 1'b0;
	logic                   cfg_write_enable = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index        = '0;
	logic [CFG_DATA_W-1:0]  cfg_data         = '0;
	logic                   byte_valid       = 1'b0;
	logic                   byte_ready;
	logic [7:0]             data_byte        = 8'd0;
	logic                   op_valid;
	logic                   op_ready         = 1'b0;
	logic [2:0]             operation;
	logic [ROW_W-1:0]       target_row;
	logic [COL_W-1:0]       target_column;
	logic [6:0]             glyph;
	logic                   highlight;
	logic                   last_of_run;

	int fail_count;
	int outstanding;
	int cycle_count   = 0;
	int words_sent    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// Effective screen size, used to aim cursor addresses at the edges
	int addr_cols     = 80;
	int addr_rows     = 24;

	// Opening words at 80 x 24, scroll mode: every code, the edges of the
	// byte, the escape both well formed and broken, and address clamping
	logic [7:0] opening_words [28] = '{
		8'h41, 8'h00, 8'h80, 8'hFF,
		{1'b0, CH_SO_ON}, 8'h78, {1'b0, CH_SO_OFF},
		{1'b0, CH_TAB}, {1'b0, CH_BS}, {1'b0, CH_FWD}, {1'b0, CH_UP},
		{1'b0, CH_LF}, {1'b0, CH_CR}, {1'b0, CH_BELL},
		{1'b0, CH_INS_LINE}, {1'b0, CH_DEL_LINE}, {1'b0, CH_EOL},
		// bottom-right corner, then a write there: wrap and scroll
		{1'b0, CH_ESC}, {1'b0, CH_EQUALS}, 8'h37, 8'h6F, 8'h7E,
		// escape not followed by '='
		{1'b0, CH_ESC}, 8'h51,
		// row and column bytes below the bias; the column byte is a control
		// code and is taken as an address
		{1'b0, CH_ESC}, {1'b0, CH_EQUALS}, 8'h10, {1'b0, CH_CLEAR}
	};

	logic [6:0] control_codes [14] = '{
		CH_CR, CH_LF, CH_UP, CH_CLEAR, CH_TAB, CH_BS, CH_SO_ON, CH_SO_OFF,
		CH_BELL, CH_FWD, CH_INS_LINE, CH_DEL_LINE, CH_EOL, CH_NUL
	};

	terminal_control_code_interpreter u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.byte_valid       (byte_valid),
		.byte_ready       (byte_ready),
		.data_byte        (data_byte),
		.op_valid         (op_valid),
		.op_ready         (op_ready),
		.operation        (operation),
		.target_row       (target_row),
		.target_column    (target_column),
		.glyph            (glyph),
		.highlight        (highlight),
		.last_of_run      (last_of_run)
	);

	terminal_control_code_interpreter_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.byte_valid       (byte_valid),
		.byte_ready       (byte_ready),
		.data_byte        (data_byte),
		.op_valid         (op_valid),
		.op_ready         (op_ready),
		.operation        (operation),
		.target_row       (target_row),
		.target_column    (target_column),
		.glyph            (glyph),
		.highlight        (highlight),
		.last_of_run      (last_of_run),
		.fail_count       (fail_count),
		.outstanding      (outstanding)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Receiver: drop ready at random, changing only on the falling edge
	always @(negedge clk) begin
		op_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offer one word; hold valid and payload until the handshake, then
	// return on the falling edge with valid still high
	task automatic send_word(input logic [7:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid = 1'b0;
			@(negedge clk);
		end
		byte_valid = 1'b1;
		data_byte  = word;
		@(posedge clk);
		while (!byte_ready)
			@(posedge clk);
		@(negedge clk);
		if (word[6:0] != CH_NUL)
			words_sent++;
	endtask

	// Random top bit: the block must ignore it
	function automatic logic [7:0] with_top_noise(input logic [6:0] code);
		return {1'($urandom_range(1)), code};
	endfunction

	// Address byte, biased towards the last row or column
	function automatic logic [6:0] address_code(input int limit);
		if ($urandom_range(3) == 0)
			return 7'($urandom_range(127));
		if ($urandom_range(2) == 0)
			return 7'(ADDR_BIAS + limit - 1);
		return 7'(ADDR_BIAS + $urandom_range(limit - 1));
	endfunction

	// Mostly text and well-formed control, some broken escapes and noise
	task automatic send_random(input int count);
		int start;
		int pick;
		start = words_sent;
		while (words_sent - start < count) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_word(with_top_noise(7'($urandom_range(32, 126))));
			end else if (pick < 63) begin
				send_word(with_top_noise(control_codes[$urandom_range(13)]));
			end else if (pick < 81) begin
				send_word(with_top_noise(CH_ESC));
				send_word(with_top_noise(CH_EQUALS));
				send_word(with_top_noise(address_code(addr_rows)));
				send_word(with_top_noise(address_code(addr_cols)));
			end else if (pick < 88) begin
				send_word(with_top_noise(CH_ESC));
				send_word(with_top_noise(7'($urandom_range(127))));
			end else if (pick < 95) begin
				if ($urandom_range(3) == 0)
					send_word(with_top_noise(7'h7F));
				else
					send_word(with_top_noise(7'($urandom_range(31))));
			end else begin
				send_word(8'($urandom_range(255)));
			end
		end
	endtask

	// Hold off the sender until every operation due has come out
	task automatic drain_results();
		byte_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
		cfg_write_enable = 1'b1;
		cfg_index        = idx;
		cfg_data         = value;
		@(negedge clk);
		cfg_write_enable = 1'b0;
	endtask

	// Go idle, then load all three screen registers
	task automatic reconfigure(input logic [7:0] cols, input logic [7:0] rows,
			input logic [7:0] mode);
		drain_results();
		write_reg(REG_SCREEN_COLUMNS, cols);
		write_reg(REG_SCREEN_ROWS, rows);
		write_reg(REG_OVERWRITE_MODE, mode);
		addr_cols = (cols == 0) ? 1 : (cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols);
		addr_rows = (rows[6:0] == 0) ? 1 :
			(rows[6:0] > MAX_ROWS) ? MAX_ROWS : int'(rows[6:0]);
	endtask

	initial begin
		// Reset once, released on a falling edge
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Sender idles lightly, receiver stalls about half the time
		send_idle_pct = 19;
		recv_idle_pct = 51;
		foreach (opening_words[i])
			send_word(opening_words[i]);
		send_random(100);
		reconfigure(8'd128, 8'd64, 8'd1);
		send_random(120);
		reconfigure(8'd1, 8'd1, 8'd0);
		send_random(100);

		// Swap the pressure: slow sender, eager receiver
		send_idle_pct = 51;
		recv_idle_pct = 19;
		// Zero-sized screen acts as one cell
		reconfigure(8'd0, 8'd0, 8'd1);
		send_random(100);
		// Values above the maxima, with stray upper bits
		reconfigure(8'hFF, 8'hFF, 8'hFF);
		write_reg(REG_SPARE, 8'hA5);
		send_random(120);
		// Shrink the screen under a cursor left far out
		reconfigure(8'd10, 8'd4, 8'd0);
		send_random(120);

		// Neither side idles
		send_idle_pct = 0;
		recv_idle_pct = 0;
		reconfigure(8'($urandom_range(1, 128)), 8'($urandom_range(1, 64)),
			8'($urandom_range(1)));
		send_random(130);
		reconfigure(8'd40, 8'd12, 8'd1);
		send_random(60);
		drain_results();
		send_random(60);
		reconfigure(8'($urandom_range(1, 128)), 8'($urandom_range(1, 64)),
			8'($urandom_range(1)));
		send_random(130);

		// Wait out the tail, then give the verdict
		drain_results();
		repeat (16) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: terminal_control_code_interpreter.f
hdl/tcci_pkg.sv
hdl/tcci_front.sv
hdl/tcci_queue.sv
hdl/tcci_back.sv
hdl/terminal_control_code_interpreter.sv
tb/terminal_control_code_interpreter_checker.sv
tb/terminal_control_code_interpreter_test.sv
